// ----- hdl/ndsc_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and constants for the strided copy address generator
package ndsc_pkg;

  // default sizes
  localparam int MAX_DIMS_DEF   = 8;
  localparam int ADDR_WIDTH_DEF = 32;

  // field widths
  localparam int CMD_W   = 2;
  localparam int SEL_W   = 3;
  localparam int FIRST_W = 16;
  localparam int STEP_W  = 32;
  localparam int EXT_W   = 16;
  localparam int OFF_W   = 32;
  localparam int STAT_W  = 2;
  localparam int CFG_W   = 4;

  // (first + position) is one bit wider than first, times the stride
  localparam int PROD_W = FIRST_W + 1 + STEP_W;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NEXT  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_SAT   = 2'd2;

  // one command transfer
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [SEL_W-1:0]   dim_sel;
    logic [FIRST_W-1:0] src_first;
    logic [STEP_W-1:0]  src_step;
    logic [FIRST_W-1:0] dst_first;
    logic [STEP_W-1:0]  dst_step;
    logic [EXT_W-1:0]   extent;
  } cmd_item_t;

  // one offset pair transfer
  typedef struct packed {
    logic [OFF_W-1:0]  src_addr;
    logic [OFF_W-1:0]  dst_addr;
    logic              last;
    logic [STAT_W-1:0] status;
  } ofs_item_t;

  // per-dimension descriptor
  typedef struct packed {
    logic [FIRST_W-1:0] src_first;
    logic [STEP_W-1:0]  src_step;
    logic [FIRST_W-1:0] dst_first;
    logic [STEP_W-1:0]  dst_step;
    logic [EXT_W-1:0]   extent;
  } desc_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic start;   // clear positions
    logic step;    // advance the odometer by one
  } cell_ctl_t;

endpackage

// ----- hdl/nd_strided_copy_address_generator.sv -----
`timescale 1ns / 1ps
// top level: command decode, cell chain, sequencer and offset output register
//
// Address generator for copying an N-dimensional sub-block between two strided
// arrays. Load a descriptor per dimension (cmd 0), start a transfer (cmd 1), then
// each next request (cmd 2) returns one source/destination offset pair, last
// dimension fastest, with last set on the final pair and status 2 when an offset
// saturates. A next request, once accepted, holds the sequencer in its calculate
// step while the per-dimension products and partial sums ripple through the row
// of MAX_DIMS cells (one register stage per cell plus the product register); the
// hand-off step then gives the pair to the output register and steps the
// odometer, and the next command is taken in the cycle after. A stalled receiver
// holds the sequencer in its hand-off step until the output register frees. The
// output register lets a new command be accepted while the previous pair still
// waits. The user must write the active_dims register through the cfg port only
// while the block is idle; the block itself does not enforce this.
module nd_strided_copy_address_generator #(
  parameter int MAX_DIMS   = ndsc_pkg::MAX_DIMS_DEF,
  parameter int ADDR_WIDTH = ndsc_pkg::ADDR_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  ndsc_pkg::cmd_item_t        cmd_data,
  output logic                       ofs_valid,
  input  logic                       ofs_stall,
  output ndsc_pkg::ofs_item_t        ofs_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ndsc_pkg::CFG_W-1:0] cfg_data
);

  localparam int SUM_W     = ndsc_pkg::PROD_W + $clog2(MAX_DIMS);
  localparam int CNT_W     = $clog2(MAX_DIMS + 1);
  localparam int OFF_LIM_W = (ADDR_WIDTH < ndsc_pkg::OFF_W) ? ADDR_WIDTH : ndsc_pkg::OFF_W;
  localparam logic [SUM_W-1:0] OFF_LIMIT =
    {{(SUM_W - OFF_LIM_W){1'b0}}, {OFF_LIM_W{1'b1}}};

  typedef enum logic [2:0] {
    IDLE = 3'b001,
    CALC = 3'b010,
    DONE = 3'b100
  } state_t;

  state_t                      state;
  logic [CNT_W-1:0]            cnt;
  logic [ndsc_pkg::CFG_W-1:0]  active_dims;
  logic                        transfer_active;

  logic                        cmd_fire;
  logic                        done_fire;
  logic                        pair_last;
  logic                        src_sat;
  logic                        dst_sat;
  ndsc_pkg::cell_ctl_t         ctl;
  ndsc_pkg::desc_t             desc;

  logic [MAX_DIMS-1:0]         dim_on;
  logic [MAX_DIMS-1:0]         dim_load;
  logic [MAX_DIMS-1:0]         dim_empty;
  logic [MAX_DIMS:0]           carry;
  logic [SUM_W-1:0]            src_acc [MAX_DIMS+1];
  logic [SUM_W-1:0]            dst_acc [MAX_DIMS+1];

  // handshakes
  assign cfg_ready = 1'b1;
  assign cmd_stall = (state != IDLE);
  assign cmd_fire  = cmd_valid && !cmd_stall;
  assign done_fire = (state == DONE) && (!ofs_valid || !ofs_stall);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_dims <= '0;
    end else if (cfg_valid && cfg_ready) begin
      active_dims <= cfg_data;
    end
  end

  // descriptor taken from the command
  assign desc.src_first = cmd_data.src_first;
  assign desc.src_step  = cmd_data.src_step;
  assign desc.dst_first = cmd_data.dst_first;
  assign desc.dst_step  = cmd_data.dst_step;
  assign desc.extent    = cmd_data.extent;

  // cell controls
  assign ctl.start = cmd_fire && (cmd_data.cmd == ndsc_pkg::CMD_START);
  assign ctl.step  = done_fire && transfer_active && !pair_last;

  // chain ends: no partial sum in, every faster dimension wraps
  assign src_acc[0]      = '0;
  assign dst_acc[0]      = '0;
  assign carry[MAX_DIMS] = 1'b1;

  // row of dimension cells
  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_cell
    assign dim_on[d]   = (d < int'(active_dims));
    assign dim_load[d] = cmd_fire && (cmd_data.cmd == ndsc_pkg::CMD_LOAD) &&
                         (int'(cmd_data.dim_sel) == d);

    ndsc_cell #(
      .SUM_W (SUM_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .active      (dim_on[d]),
      .load        (dim_load[d]),
      .desc        (desc),
      .ctl         (ctl),
      .carry_in    (carry[d+1]),
      .carry_out   (carry[d]),
      .src_acc_in  (src_acc[d]),
      .dst_acc_in  (dst_acc[d]),
      .src_acc_out (src_acc[d+1]),
      .dst_acc_out (dst_acc[d+1]),
      .empty       (dim_empty[d])
    );
  end

  // final pair when every active dimension sits at its end
  assign pair_last = carry[0];
  assign src_sat   = src_acc[MAX_DIMS] > OFF_LIMIT;
  assign dst_sat   = dst_acc[MAX_DIMS] > OFF_LIMIT;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          cnt <= '0;
          if (cmd_fire && (cmd_data.cmd == ndsc_pkg::CMD_NEXT)) begin
            state <= CALC;
          end
        end
        CALC: begin
          if (cnt == CNT_W'(MAX_DIMS)) begin
            state <= DONE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        DONE: begin
          if (done_fire) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // transfer running flag
  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_active <= 1'b0;
    end else if (ctl.start) begin
      transfer_active <= !(|dim_empty);
    end else if (done_fire && transfer_active && pair_last) begin
      transfer_active <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ofs_valid <= 1'b0;
    end else if (done_fire) begin
      ofs_valid <= 1'b1;
    end else if (!ofs_stall) begin
      ofs_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      if (!transfer_active) begin
        ofs_data.src_addr <= '0;
        ofs_data.dst_addr <= '0;
        ofs_data.last     <= 1'b0;
        ofs_data.status   <= ndsc_pkg::ST_EMPTY;
      end else begin
        ofs_data.src_addr <= src_sat ? OFF_LIMIT[ndsc_pkg::OFF_W-1:0]
                                     : src_acc[MAX_DIMS][ndsc_pkg::OFF_W-1:0];
        ofs_data.dst_addr <= dst_sat ? OFF_LIMIT[ndsc_pkg::OFF_W-1:0]
                                     : dst_acc[MAX_DIMS][ndsc_pkg::OFF_W-1:0];
        ofs_data.last     <= pair_last;
        ofs_data.status   <= (src_sat || dst_sat) ? ndsc_pkg::ST_SAT : ndsc_pkg::ST_OK;
      end
    end
  end

endmodule

// ----- hdl/ndsc_cell.sv -----
`timescale 1ns / 1ps
// one dimension cell: descriptor, position, product and partial-sum stage
module ndsc_cell #(
  parameter int SUM_W = ndsc_pkg::PROD_W + 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  active,
  input  logic                  load,
  input  ndsc_pkg::desc_t       desc,
  input  ndsc_pkg::cell_ctl_t   ctl,
  input  logic                  carry_in,
  output logic                  carry_out,
  input  logic [SUM_W-1:0]      src_acc_in,
  input  logic [SUM_W-1:0]      dst_acc_in,
  output logic [SUM_W-1:0]      src_acc_out,
  output logic [SUM_W-1:0]      dst_acc_out,
  output logic                  empty
);

  ndsc_pkg::desc_t                  dsc;
  logic [ndsc_pkg::EXT_W-1:0]       pos;
  logic [ndsc_pkg::PROD_W-1:0]      src_prod;
  logic [ndsc_pkg::PROD_W-1:0]      dst_prod;
  logic [ndsc_pkg::EXT_W:0]         pos_inc;
  logic                             at_end;
  logic [ndsc_pkg::FIRST_W:0]       src_idx;
  logic [ndsc_pkg::FIRST_W:0]       dst_idx;

  // descriptor store
  always_ff @(posedge clk) begin
    if (load) begin
      dsc <= desc;
    end
  end

  // dimension finished when the next position would leave the extent
  assign pos_inc = {1'b0, pos} + {{ndsc_pkg::EXT_W{1'b0}}, 1'b1};
  assign at_end  = !active || (pos_inc >= {1'b0, dsc.extent});
  assign empty   = active && (dsc.extent == '0);

  // odometer digit: the carry comes from the faster dimension
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (ctl.start) begin
      pos <= '0;
    end else if (ctl.step && active && carry_in) begin
      pos <= at_end ? '0 : pos_inc[ndsc_pkg::EXT_W-1:0];
    end
  end

  // carry chain toward the slower dimensions
  always_ff @(posedge clk) begin
    carry_out <= at_end && carry_in;
  end

  // element index along this dimension
  assign src_idx = {1'b0, dsc.src_first} + {1'b0, pos};
  assign dst_idx = {1'b0, dsc.dst_first} + {1'b0, pos};

  // product terms, one multiply each
  always_ff @(posedge clk) begin
    src_prod <= ndsc_pkg::PROD_W'(src_idx) * ndsc_pkg::PROD_W'(dsc.src_step);
    dst_prod <= ndsc_pkg::PROD_W'(dst_idx) * ndsc_pkg::PROD_W'(dsc.dst_step);
  end

  // partial sums ripple to the next cell
  always_ff @(posedge clk) begin
    src_acc_out <= src_acc_in + (active ? SUM_W'(src_prod) : '0);
    dst_acc_out <= dst_acc_in + (active ? SUM_W'(dst_prod) : '0);
  end

endmodule

// ----- test/nd_strided_copy_address_generator_test.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the strided copy address generator, with random walks and stalls
module nd_strided_copy_address_generator_test;

  localparam int NUM_DIMS = ndsc_pkg::MAX_DIMS_DEF;
  localparam logic [63:0] OFFSET_MAX = (ndsc_pkg::ADDR_WIDTH_DEF >= 32) ? 64'hFFFF_FFFF :
                                       ((64'd1 << ndsc_pkg::ADDR_WIDTH_DEF) - 64'd1);
  localparam logic [ndsc_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 2 * (NUM_DIMS + 3) + 4;
  localparam int HOLD_CYCLES  = 200;
  localparam int ITEM_TARGET  = 1000;
  localparam int CYCLE_LIMIT  = 500000;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cmd_valid = 1'b0;
  logic                          cmd_stall;
  ndsc_pkg::cmd_item_t           cmd_data = '0;
  logic                          ofs_valid;
  logic                          ofs_stall = 1'b0;
  ndsc_pkg::ofs_item_t           ofs_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [ndsc_pkg::CFG_W-1:0]    cfg_data = '0;

  // predictor state
  logic [ndsc_pkg::FIRST_W-1:0] src_first_tab [NUM_DIMS];
  logic [ndsc_pkg::FIRST_W-1:0] dst_first_tab [NUM_DIMS];
  logic [ndsc_pkg::STEP_W-1:0]  src_step_tab  [NUM_DIMS];
  logic [ndsc_pkg::STEP_W-1:0]  dst_step_tab  [NUM_DIMS];
  logic [ndsc_pkg::EXT_W-1:0]   ext_tab       [NUM_DIMS];
  logic [ndsc_pkg::EXT_W-1:0]   walk_pos      [NUM_DIMS];
  bit                           walk_armed = 1'b0;
  logic [ndsc_pkg::CFG_W-1:0]   dims_cfg = '0;

  ndsc_pkg::ofs_item_t pairs_due [$];
  int        errors = 0;
  int        items_sent = 0;
  bit        src_idle = 1'b1;
  bit        sink_idle = 1'b1;
  bit        hold_req = 1'b0;

  nd_strided_copy_address_generator dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .ofs_valid (ofs_valid),
    .ofs_stall (ofs_stall),
    .ofs_data  (ofs_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int dims_used();
    return (int'(dims_cfg) > NUM_DIMS) ? NUM_DIMS : int'(dims_cfg);
  endfunction

  // update the walker for one accepted command and queue the pair it yields
  task automatic advance_walker(input ndsc_pkg::cmd_item_t c);
    int n;
    int d;
    bit sat;
    bit fin;
    bit carry;
    logic [63:0] so;
    logic [63:0] dof;
    ndsc_pkg::ofs_item_t r;
    n = dims_used();
    case (c.cmd)
      ndsc_pkg::CMD_LOAD: begin
        if (int'(c.dim_sel) < NUM_DIMS) begin
          src_first_tab[c.dim_sel] = c.src_first;
          src_step_tab[c.dim_sel]  = c.src_step;
          dst_first_tab[c.dim_sel] = c.dst_first;
          dst_step_tab[c.dim_sel]  = c.dst_step;
          ext_tab[c.dim_sel]       = c.extent;
        end
      end
      ndsc_pkg::CMD_START: begin
        walk_armed = 1'b1;
        for (d = 0; d < NUM_DIMS; d++) walk_pos[d] = '0;
        for (d = 0; d < n; d++) if (ext_tab[d] == '0) walk_armed = 1'b0;
      end
      ndsc_pkg::CMD_NEXT: begin
        if (!walk_armed) begin
          r.src_addr = '0;
          r.dst_addr = '0;
          r.last     = 1'b0;
          r.status   = ndsc_pkg::ST_EMPTY;
        end else begin
          so  = '0;
          dof = '0;
          fin = 1'b1;
          for (d = 0; d < n; d++) begin
            so  += (64'(src_first_tab[d]) + 64'(walk_pos[d])) * 64'(src_step_tab[d]);
            dof += (64'(dst_first_tab[d]) + 64'(walk_pos[d])) * 64'(dst_step_tab[d]);
            if (32'(walk_pos[d]) + 32'd1 < 32'(ext_tab[d])) fin = 1'b0;
          end
          sat = (so > OFFSET_MAX) || (dof > OFFSET_MAX);
          if (so > OFFSET_MAX) so = OFFSET_MAX;
          if (dof > OFFSET_MAX) dof = OFFSET_MAX;
          // row-major odometer, last dimension fastest
          if (fin) begin
            walk_armed = 1'b0;
          end else begin
            carry = 1'b1;
            for (d = n - 1; d >= 0; d--) begin
              if (carry) begin
                if (32'(walk_pos[d]) + 32'd1 < 32'(ext_tab[d])) begin
                  walk_pos[d] = walk_pos[d] + ndsc_pkg::EXT_W'(1);
                  carry = 1'b0;
                end else begin
                  walk_pos[d] = '0;
                end
              end
            end
          end
          r.src_addr = so[ndsc_pkg::OFF_W-1:0];
          r.dst_addr = dof[ndsc_pkg::OFF_W-1:0];
          r.last     = fin;
          r.status   = sat ? ndsc_pkg::ST_SAT : ndsc_pkg::ST_OK;
        end
        pairs_due.push_back(r);
      end
      default: ;
    endcase
  endtask

  // one command transfer; returns just after the accepting edge
  task automatic send_cmd(input ndsc_pkg::cmd_item_t item);
    @(negedge clk);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data  <= item;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    advance_walker(item);
    if (item.cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic quiet_cmd();
    @(negedge clk);
    cmd_valid <= 1'b0;
  endtask

  function automatic ndsc_pkg::cmd_item_t make_cmd(
      input logic [ndsc_pkg::CMD_W-1:0] op,
      input logic [ndsc_pkg::SEL_W-1:0] sel,
      input logic [ndsc_pkg::FIRST_W-1:0] sf,
      input logic [ndsc_pkg::STEP_W-1:0] ss,
      input logic [ndsc_pkg::FIRST_W-1:0] df,
      input logic [ndsc_pkg::STEP_W-1:0] ds,
      input logic [ndsc_pkg::EXT_W-1:0] ext);
    ndsc_pkg::cmd_item_t c;
    c.cmd       = op;
    c.dim_sel   = sel;
    c.src_first = sf;
    c.src_step  = ss;
    c.dst_first = df;
    c.dst_step  = ds;
    c.extent    = ext;
    return c;
  endfunction

  task automatic load_dim(input int sel, input logic [ndsc_pkg::FIRST_W-1:0] sf,
                          input logic [ndsc_pkg::STEP_W-1:0] ss,
                          input logic [ndsc_pkg::FIRST_W-1:0] df,
                          input logic [ndsc_pkg::STEP_W-1:0] ds,
                          input logic [ndsc_pkg::EXT_W-1:0] ext);
    send_cmd(make_cmd(ndsc_pkg::CMD_LOAD, ndsc_pkg::SEL_W'(sel), sf, ss, df, ds, ext));
  endtask

  // start, next or unused command with a random payload that must be ignored
  task automatic issue(input logic [ndsc_pkg::CMD_W-1:0] op);
    send_cmd(make_cmd(op, ndsc_pkg::SEL_W'($urandom), ndsc_pkg::FIRST_W'($urandom),
                      $urandom, ndsc_pkg::FIRST_W'($urandom), $urandom,
                      ndsc_pkg::EXT_W'($urandom)));
  endtask

  function automatic logic [ndsc_pkg::STEP_W-1:0] rand_step();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return '0;
      default: return ndsc_pkg::STEP_W'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [ndsc_pkg::FIRST_W-1:0] rand_first();
    return ($urandom_range(0, 1) == 0) ? ndsc_pkg::FIRST_W'($urandom)
                                       : ndsc_pkg::FIRST_W'($urandom_range(0, 63));
  endfunction

  task automatic load_random_dim(input int sel, input logic [ndsc_pkg::EXT_W-1:0] ext);
    load_dim(sel, rand_first(), rand_step(), rand_first(), rand_step(), ext);
  endtask

  // active_dims is only written with nothing in flight
  task automatic write_dims(input logic [ndsc_pkg::CFG_W-1:0] value);
    quiet_cmd();
    while (pairs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    dims_cfg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // requests with no dimensions in use, before any table is loaded
  task automatic test_zero_dims();
    issue(ndsc_pkg::CMD_NEXT);
    issue(ndsc_pkg::CMD_START);
    issue(ndsc_pkg::CMD_NEXT);
    issue(ndsc_pkg::CMD_NEXT);
    issue(CMD_UNUSED);
  endtask

  // every descriptor gets a value so later walks never read an empty entry
  task automatic test_fill_tables();
    int d;
    for (d = 0; d < NUM_DIMS; d++) load_random_dim(d, 16'd1);
  endtask

  task automatic test_directed_cases();
    // saturating source, zero destination stride, largest extent
    write_dims(4'd1);
    load_dim(0, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000, 32'h0000_0000, 16'hFFFF);
    issue(ndsc_pkg::CMD_START);
    issue(ndsc_pkg::CMD_NEXT);
    issue(ndsc_pkg::CMD_NEXT);
    // short walk, then a request past the end
    load_dim(0, 16'h0000, 32'h0000_0001, 16'hFFFF, 32'h0000_0001, 16'd2);
    issue(ndsc_pkg::CMD_START);
    issue(ndsc_pkg::CMD_NEXT);
    issue(ndsc_pkg::CMD_NEXT);
    issue(ndsc_pkg::CMD_NEXT);
    // all dimensions in use
    write_dims(4'd8);
    issue(ndsc_pkg::CMD_START);
    issue(ndsc_pkg::CMD_NEXT);
    // zero extent leaves nothing armed
    load_dim(3, 16'h1234, 32'h0000_0010, 16'h4321, 32'h0000_0020, 16'd0);
    issue(ndsc_pkg::CMD_START);
    issue(ndsc_pkg::CMD_NEXT);
    load_dim(3, 16'h1234, 32'h0000_0010, 16'h4321, 32'h0000_0020, 16'd1);
    // out-of-range dimension count, then shrink an extent mid-walk
    write_dims(4'd15);
    load_dim(7, 16'h0001, 32'h0000_0003, 16'h0002, 32'h0000_0005, 16'd3);
    issue(ndsc_pkg::CMD_START);
    issue(ndsc_pkg::CMD_NEXT);
    issue(ndsc_pkg::CMD_NEXT);
    load_dim(7, 16'h0001, 32'h0000_0003, 16'h0002, 32'h0000_0005, 16'd1);
    issue(ndsc_pkg::CMD_NEXT);
    issue(ndsc_pkg::CMD_NEXT);
    issue(CMD_UNUSED);
  endtask

  // receiver holds off while requests keep coming, so the input backs up
  task automatic test_backpressure();
    write_dims(4'd2);
    load_dim(0, 16'd5, 32'd100, 16'd7, 32'd64, 16'd8);
    load_dim(1, 16'd1, 32'd3, 16'd2, 32'd1, 16'd8);
    issue(ndsc_pkg::CMD_START);
    src_idle = 1'b0;
    hold_req = 1'b1;
    repeat (30) issue(ndsc_pkg::CMD_NEXT);
    quiet_cmd();
    while (hold_req) @(posedge clk);
    src_idle = 1'b1;
  endtask

  // well-formed walks with random content, mixed with mid-walk changes
  task automatic test_random_walks(input int target);
    int n;
    int d;
    int k;
    int cap;
    int pick;
    logic [ndsc_pkg::EXT_W-1:0] ext;
    while (items_sent < target) begin
      if ($urandom_range(0, 5) == 0) write_dims(ndsc_pkg::CFG_W'($urandom_range(0, 15)));
      n = dims_used();
      for (d = 0; d < n; d++) begin
        pick = $urandom_range(0, 31);
        if (pick == 0) ext = '0;
        else if (pick == 1) ext = ndsc_pkg::EXT_W'($urandom);
        else ext = ndsc_pkg::EXT_W'($urandom_range(1, (n <= 2) ? 8 : 2));
        load_random_dim(d, ext);
      end
      issue(ndsc_pkg::CMD_START);
      k = 0;
      cap = $urandom_range(4, 48);
      while (walk_armed && k < cap) begin
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
          load_random_dim($urandom_range(0, NUM_DIMS - 1), ndsc_pkg::EXT_W'($urandom));
        end else if (pick == 1) begin
          issue(CMD_UNUSED);
        end else begin
          issue(ndsc_pkg::CMD_NEXT);
        end
        k++;
      end
      if ($urandom_range(0, 3) == 0) issue(ndsc_pkg::CMD_NEXT);
    end
  endtask

  // receiver stalls: random bursts, plus the long hold on request
  initial begin : sink_stall
    int hold_count;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        ofs_stall <= 1'b1;
        hold_count = 0;
        while (hold_count < HOLD_CYCLES) begin
          @(negedge clk);
          hold_count++;
        end
        ofs_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        ofs_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        ofs_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(input string what, input logic [ndsc_pkg::OFF_W-1:0] want,
                             input logic [ndsc_pkg::OFF_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // compare each offset pair transfer with the oldest expected pair
  always @(posedge clk) begin : check_pairs
    ndsc_pkg::ofs_item_t want;
    if (!rst && ofs_valid && !ofs_stall) begin
      if (pairs_due.size() == 0) begin
        errors++;
        $display("%0t: offset pair mismatch, expected none, got %h", $time, ofs_data);
      end else begin
        want = pairs_due.pop_front();
        check_field("src_addr", want.src_addr, ofs_data.src_addr);
        check_field("dst_addr", want.dst_addr, ofs_data.dst_addr);
        check_field("last", ndsc_pkg::OFF_W'(want.last), ndsc_pkg::OFF_W'(ofs_data.last));
        check_field("status", ndsc_pkg::OFF_W'(want.status),
                    ndsc_pkg::OFF_W'(ofs_data.status));
      end
    end
  end

  // run limit
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // test sequence
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_zero_dims();
    test_fill_tables();
    test_directed_cases();
    test_backpressure();
    test_random_walks(ITEM_TARGET - 150);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    test_random_walks(ITEM_TARGET);
    quiet_cmd();
    while (pairs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
